[design/i2c_eeprom_paged_master_assert.svh]
// Assertion macros shared by the front and back end design files.
`ifndef I2C_EEPROM_PAGED_MASTER_ASSERT_SVH
`define I2C_EEPROM_PAGED_MASTER_ASSERT_SVH
`ifndef SYNTHESIS
`define IEPM_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define IEPM_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m: label");
`else
`define IEPM_ASSERT_IMPL(label, clk, rst, prop)
`define IEPM_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

[design/iepm_pkg.sv]
`timescale 1ns / 1ps
package iepm_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_WRITE = 2'd3;

   localparam logic [1:0] CSR_DEVICE_SELECT = 2'd0;
   localparam logic [1:0] CSR_ACK_TIMEOUT   = 2'd1;
   localparam logic [1:0] CSR_POLL_LIMIT    = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_ACK  = 2'd1;
   localparam logic [1:0] ST_POLL    = 2'd2;

   localparam int CSR_DATA_WIDTH = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_AW       = 2;
   localparam int BUFFER_DEPTH   = 256;
   localparam int BUF_AW         = 8;
   localparam int PAGE_SIZE      = 32;

   typedef enum logic [4:0] {
      PH_IDLE, PH_SEGSTOP, PH_START1, PH_CTRLW, PH_ACKW, PH_AHI, PH_ACKHI, PH_ALO,
      PH_ACKLO, PH_RESTART, PH_CTRLR, PH_ACKR, PH_RDATA, PH_MACK, PH_WDATA, PH_WACK,
      PH_FSTOP
   } phase_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        sda_in;
      logic [15:0] mem_address;
      logic [8:0]  byte_count;
      logic [7:0]  buffer_index;
      logic [7:0]  load_byte;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       read_valid;
      logic [7:0] read_data;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        sda_in;
      logic [15:0] mem_address;
      logic [8:0]  byte_count;
   } cmd_type;

   typedef struct packed {
      logic [6:0]  device_select;
      logic [15:0] ack_timeout;
      logic [7:0]  poll_limit;
   } csr_type;

endpackage

[design/iepm_front.sv]
`timescale 1ns / 1ps
module iepm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  iepm_pkg::req_type           req_data,
   output logic                        req_full,
   output iepm_pkg::cmd_type           cmd_data,
   output logic                        cmd_valid,
   input  logic                        cmd_pop,
   input  logic [iepm_pkg::BUF_AW-1:0] buf_rd_addr,
   output logic [7:0]                  buf_rd_data
);
   import iepm_pkg::*;

   logic [7:0]          mem_ff [BUFFER_DEPTH];
   req_type             queue_ff [QUEUE_DEPTH];
   req_type             head;
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                accept, load_ok, enq;

   assign req_full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign accept    = req_push && !req_full;
   assign enq       = accept;
   assign head      = queue_ff[rd_ptr_ff];
   assign load_ok   = cmd_pop && (head.opcode == OP_LOAD)
                      && ({24'd0, head.buffer_index} < 32'(BUFFER_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = '{opcode: head.opcode, sda_in: head.sda_in,
                        mem_address: head.mem_address, byte_count: head.byte_count};

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(enq) - (QUEUE_AW+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok) begin
         mem_ff[head.buffer_index[BUF_AW-1:0]] <= head.load_byte;
      end
      buf_rd_data <= mem_ff[buf_rd_addr];
   end

   `include "i2c_eeprom_paged_master_assert.svh"
   `IEPM_ASSERT_NEVER(a_no_underflow, clock, reset, cmd_pop && !cmd_valid)
   `IEPM_ASSERT_NEVER(a_no_overflow, clock, reset, enq && count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH))
   `IEPM_ASSERT_IMPL(a_count_tracks, clock, reset, (enq && !cmd_pop) |=> count_ff == $past(count_ff) + 1'b1)
endmodule

[design/iepm_back.sv]
`timescale 1ns / 1ps
module iepm_back #(
   parameter int ADDRESS_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  iepm_pkg::csr_type           csr,
   input  iepm_pkg::cmd_type           cmd_data,
   input  logic                        cmd_valid,
   output logic                        cmd_pop,
   output logic [iepm_pkg::BUF_AW-1:0] buf_rd_addr,
   input  logic [7:0]                  buf_rd_data,
   output iepm_pkg::rsp_type           rsp_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready
);
   import iepm_pkg::*;

   localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDRESS_BITS) - 1);
   localparam logic [15:0] PAGE_MASK = 16'(PAGE_SIZE - 1);

   phase_type   phase_ff, phase_in;
   logic [4:0]  slot_ff, slot_in;
   logic [7:0]  shift_ff, shift_in, shift_cur;
   logic [15:0] addr_ff, addr_in;
   logic [8:0]  left_ff, left_in, pos_ff, pos_in;
   logic [15:0] wait_ff, wait_in;
   logic [7:0]  polls_ff, polls_in;
   logic        reading_ff, reading_in, acked_ff, acked_in;
   logic        scl_ff, scl_in, sda_ff, sda_in_lvl;
   logic        pend_ff, pend_in;
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   logic        step, fin, bit_first;
   logic [1:0]  r3;
   logic [1:0]  fail;
   logic        valid_b, done_b;
   logic [7:0]  rdata_b;
   logic [15:0] tmo, waitn;
   logic [7:0]  plim, pollsn;
   phase_type   nxt;
   logic        ld;

   assign step    = cmd_valid && (!out_valid_ff || rsp_ready);
   assign cmd_pop = step;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign buf_rd_addr = pos_in[BUF_AW-1:0];
   assign shift_cur = pend_ff ? buf_rd_data : shift_ff;
   assign tmo  = (csr.ack_timeout == 16'd0) ? 16'd1 : csr.ack_timeout;
   assign plim = (csr.poll_limit == 8'd0) ? 8'd1 : csr.poll_limit;
   assign r3   = (slot_ff < 5'd3) ? slot_ff[1:0] : (slot_ff < 5'd6) ? 2'(slot_ff - 5'd3)
               : (slot_ff < 5'd9) ? 2'(slot_ff - 5'd6) : (slot_ff < 5'd12) ? 2'(slot_ff - 5'd9)
               : (slot_ff < 5'd15) ? 2'(slot_ff - 5'd12) : (slot_ff < 5'd18) ? 2'(slot_ff - 5'd15)
               : (slot_ff < 5'd21) ? 2'(slot_ff - 5'd18) : 2'(slot_ff - 5'd21);
   assign bit_first = (phase_ff == PH_START1) || (phase_ff == PH_RESTART);

   always_comb begin
      phase_in = phase_ff; slot_in = slot_ff; shift_in = shift_ff; addr_in = addr_ff;
      left_in = left_ff; pos_in = pos_ff; wait_in = wait_ff; polls_in = polls_ff;
      reading_in = reading_ff; acked_in = acked_ff; scl_in = scl_ff; sda_in_lvl = sda_ff;
      pend_in = pend_ff; out_in = out_ff; out_valid_in = out_valid_ff && !rsp_ready;
      fin = 1'b0; fail = ST_OK; valid_b = 1'b0; rdata_b = 8'd0; done_b = 1'b0;
      nxt = phase_ff; ld = 1'b0; waitn = wait_ff + 16'd1; pollsn = polls_ff + 8'd1;
      if (pend_ff) begin
         shift_in = buf_rd_data;
         pend_in  = 1'b0;
      end
      if (step) begin
         if (cmd_data.opcode >= OP_READ) begin
            if (phase_ff == PH_IDLE) begin
               addr_in = cmd_data.mem_address & ADDR_MASK;
               left_in = cmd_data.byte_count;
               pos_in  = 9'd0;
               reading_in = (cmd_data.opcode == OP_READ);
               ld = 1'b1;
               nxt = (cmd_data.opcode == OP_READ) ? PH_START1
                   : (cmd_data.byte_count != 9'd0) ? PH_SEGSTOP : PH_FSTOP;
            end
         end else if (cmd_data.opcode == OP_TICK && phase_ff != PH_IDLE) begin
            slot_in = slot_ff + 5'd1;
            unique case (phase_ff)
               PH_START1, PH_RESTART, PH_SEGSTOP, PH_FSTOP: begin
                  if (slot_ff == 5'd0) scl_in = 1'b0;
                  else if (slot_ff == 5'd1) sda_in_lvl = bit_first;
                  else if (slot_ff == 5'd2) scl_in = 1'b1;
                  else if (slot_ff == 5'd3) sda_in_lvl = !bit_first;
                  else begin scl_in = 1'b0; fin = 1'b1; end
               end
               PH_CTRLW, PH_AHI, PH_ALO, PH_CTRLR, PH_WDATA: begin
                  if (slot_ff < 5'd24) begin
                     if (r3 == 2'd0) begin scl_in = 1'b0; sda_in_lvl = shift_cur[7]; end
                     else if (r3 == 2'd1) scl_in = 1'b1;
                     else begin scl_in = 1'b0; shift_in = {shift_cur[6:0], 1'b0}; end
                  end else begin
                     sda_in_lvl = 1'b1; fin = 1'b1;
                  end
               end
               PH_RDATA: begin
                  if (r3 == 2'd0) begin sda_in_lvl = 1'b1; scl_in = 1'b1; end
                  else if (r3 == 2'd1) shift_in = {shift_ff[6:0], cmd_data.sda_in};
                  else begin scl_in = 1'b0; fin = (slot_ff >= 5'd23); end
               end
               PH_MACK: begin
                  if (slot_ff == 5'd0) scl_in = 1'b0;
                  else if (slot_ff == 5'd1) sda_in_lvl = (left_ff == 9'd0);
                  else if (slot_ff == 5'd2) scl_in = 1'b1;
                  else begin scl_in = 1'b0; fin = 1'b1; end
               end
               default: begin
                  if (slot_ff == 5'd0) scl_in = 1'b0;
                  else if (slot_ff == 5'd1) sda_in_lvl = 1'b1;
                  else if (slot_ff == 5'd2) begin scl_in = 1'b1; wait_in = 16'd0; end
                  else if (slot_ff == 5'd3) begin
                     if (!cmd_data.sda_in) acked_in = 1'b1;
                     else begin
                        wait_in = waitn;
                        if (waitn >= tmo) acked_in = 1'b0;
                        else slot_in = 5'd3;
                     end
                  end else if (slot_ff == 5'd4) scl_in = 1'b1;
                  else begin scl_in = 1'b0; fin = 1'b1; end
               end
            endcase
            if (fin) begin
               ld = 1'b1;
               unique case (phase_ff)
                  PH_SEGSTOP: nxt = PH_START1;
                  PH_START1:  nxt = PH_CTRLW;
                  PH_CTRLW:   nxt = PH_ACKW;
                  PH_ACKW: begin
                     if (acked_in) nxt = (ADDRESS_BITS > 8) ? PH_AHI : PH_ALO;
                     else if (reading_ff) fail = ST_NO_ACK;
                     else begin
                        polls_in = pollsn;
                        if (pollsn >= plim) fail = ST_POLL;
                        else nxt = PH_START1;
                     end
                  end
                  PH_AHI:    nxt = PH_ACKHI;
                  PH_ACKHI:  if (acked_in) nxt = PH_ALO; else fail = ST_NO_ACK;
                  PH_ALO:    nxt = PH_ACKLO;
                  PH_ACKLO:  if (acked_in) nxt = reading_ff ? PH_RESTART : PH_WDATA;
                             else fail = ST_NO_ACK;
                  PH_RESTART: nxt = PH_CTRLR;
                  PH_CTRLR:  nxt = PH_ACKR;
                  PH_ACKR:   if (acked_in) nxt = (left_ff != 9'd0) ? PH_RDATA : PH_FSTOP;
                             else fail = ST_NO_ACK;
                  PH_RDATA: begin
                     valid_b = 1'b1; rdata_b = shift_in;
                     left_in = left_ff - 9'd1;
                     nxt = PH_MACK;
                  end
                  PH_MACK:   nxt = (left_ff != 9'd0) ? PH_RDATA : PH_FSTOP;
                  PH_WDATA:  nxt = PH_WACK;
                  PH_WACK: begin
                     if (!acked_in) fail = ST_NO_ACK;
                     else begin
                        pos_in  = pos_ff + 9'd1;
                        addr_in = (addr_ff + 16'd1) & ADDR_MASK;
                        left_in = left_ff - 9'd1;
                        if (left_in == 9'd0) nxt = PH_FSTOP;
                        else if ((addr_in & PAGE_MASK) == 16'd0) nxt = PH_SEGSTOP;
                        else nxt = PH_WDATA;
                     end
                  end
                  default: begin
                     ld = 1'b0; done_b = 1'b1; nxt = PH_IDLE;
                  end
               endcase
               if (fail != ST_OK) begin
                  ld = 1'b0; done_b = 1'b1; nxt = PH_IDLE;
               end
            end
         end
         phase_in = nxt;
         if (ld) begin
            slot_in = 5'd0;
            unique case (nxt)
               PH_SEGSTOP: polls_in = 8'd0;
               PH_CTRLW:   shift_in = {csr.device_select, 1'b0};
               PH_CTRLR:   shift_in = {csr.device_select, 1'b1};
               PH_AHI:     shift_in = addr_in[15:8];
               PH_ALO:     shift_in = addr_in[7:0];
               PH_WDATA:   pend_in = 1'b1;
               PH_RDATA:   shift_in = 8'd0;
               default:    ;
            endcase
         end
         out_in = '{scl_out: scl_in, sda_out: sda_in_lvl, busy_res: (nxt != PH_IDLE),
                    read_valid: valid_b, read_data: rdata_b, done_res: done_b,
                    status: fail};
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; slot_ff <= '0; shift_ff <= '0; addr_ff <= '0;
         left_ff <= '0; pos_ff <= '0; wait_ff <= '0; polls_ff <= '0;
         reading_ff <= 1'b0; acked_ff <= 1'b0; scl_ff <= 1'b0; sda_ff <= 1'b1;
         pend_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; slot_ff <= slot_in; shift_ff <= shift_in; addr_ff <= addr_in;
         left_ff <= left_in; pos_ff <= pos_in; wait_ff <= wait_in; polls_ff <= polls_in;
         reading_ff <= reading_in; acked_ff <= acked_in; scl_ff <= scl_in;
         sda_ff <= sda_in_lvl; pend_ff <= pend_in; out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   `include "i2c_eeprom_paged_master_assert.svh"
   `IEPM_ASSERT_IMPL(a_done_idle, clock, reset, (step && done_b) |=> phase_ff == PH_IDLE)
   `IEPM_ASSERT_NEVER(a_slot_range, clock, reset, slot_ff > 5'd24)
   `IEPM_ASSERT_IMPL(a_hold_out, clock, reset, (out_valid_ff && !rsp_ready) |=> $stable(out_ff))
endmodule

[design/i2c_eeprom_paged_master.sv]
`timescale 1ns / 1ps
// Bit-level I2C master for a paged serial EEPROM. Each tick request is one bus delay
// slot and yields one result with the SCL and SDA levels; load, read and write requests
// also yield one result each. One request is taken per cycle unless the result register
// is full and not popped, and its result is registered for the cycle after; the rate is
// set by the bus sequencer in the back end, with a four-entry request queue in front and
// a one-entry result register behind it. Loads reach the write buffer as they leave the
// queue, in order with the bus steps. The buffer is read at the next byte position, so
// each byte is ready in the first slot of its send.
module i2c_eeprom_paged_master #(
   parameter int ADDRESS_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  iepm_pkg::req_type req_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output iepm_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import iepm_pkg::*;

   csr_type           csr_ff;
   cmd_type           cmd_data;
   logic              cmd_valid, cmd_pop, rsp_valid;
   logic [BUF_AW-1:0] buf_rd_addr;
   logic [7:0]        buf_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{device_select: 7'd80, ack_timeout: 16'd65530, poll_limit: 8'd100};
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEVICE_SELECT: csr_ff.device_select <= csr_data[6:0];
            CSR_ACK_TIMEOUT:   csr_ff.ack_timeout   <= csr_data;
            CSR_POLL_LIMIT:    csr_ff.poll_limit    <= csr_data[7:0];
            default:           ;
         endcase
      end
   end

   iepm_front u_front (
      .clock, .reset, .req_push(push), .req_data, .req_full(full),
      .cmd_data, .cmd_valid, .cmd_pop, .buf_rd_addr, .buf_rd_data
   );

   iepm_back #(.ADDRESS_BITS(ADDRESS_BITS)) u_back (
      .clock, .reset, .csr(csr_ff), .cmd_data, .cmd_valid, .cmd_pop,
      .buf_rd_addr, .buf_rd_data, .rsp_data, .rsp_valid, .rsp_ready(pop)
   );

   assign empty = !rsp_valid;
endmodule
